FILE: sv/gla_pkg.sv
`default_nettype none
package gla_pkg;

  localparam int unsigned MaxCells = 32;
  localparam int unsigned IdxW     = $clog2(MaxCells);
  localparam int unsigned CntW     = $clog2(MaxCells + 1);
  localparam int unsigned VecW     = 32;
  localparam int unsigned RuleW    = 33;
  localparam int unsigned CfgW     = 33;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [VecW-1:0] CellMask = VecW'((64'd1 << MaxCells) - 64'd1);

  // request function codes
  localparam logic [1:0] FuncLoadNbr   = 2'd0;
  localparam logic [1:0] FuncLoadState = 2'd1;
  localparam logic [1:0] FuncStep      = 2'd2;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] RegBirth    = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSurvival = 2'd1;
  localparam logic [CfgAddrW-1:0] RegCount    = 2'd2;

  localparam logic [5:0] CountReset = 6'd32;

  typedef struct packed {
    logic [VecW-1:0]  nbr;
    logic [VecW-1:0]  alive;
    logic [VecW-1:0]  in_use;
    logic [RuleW-1:0] birth;
    logic [RuleW-1:0] survival;
    logic             self_alive;
  } cell_req_t;

endpackage
`default_nettype wire

FILE: sv/graph_life_automaton_step.sv
`default_nettype none
// Life-like automaton on a graph of up to 32 cells. Each request returns the
// state vector as it stands after the request. Loading a neighbor mask, loading
// the state vector or an unused function code returns its result in the cycle
// after acceptance. A generation passes through the run and finish states; one
// shared neighbor-count unit visits the cells in use one per cycle, fed from the
// single read port of the neighbor memory. The block takes no new request until
// the result of the previous one has entered the output register; a pending
// result blocks no request as long as it is taken in the same cycle.
// Configuration must only be written while the block is idle.
module graph_life_automaton_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gla_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [gla_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   func_i,
  input  wire logic [4:0]                   cell_index_i,
  input  wire logic [31:0]                  value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [31:0]                  cell_states_o
);
  import gla_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [RuleW-1:0] birth_q, survival_q;
  logic [5:0]       count_q;
  logic [1:0]       state_q, state_d;
  logic [VecW-1:0]  alive_q, alive_d;
  logic [VecW-1:0]  next_q, next_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic             out_vld_q, out_vld_d;
  logic [VecW-1:0]  out_data_q, out_data_d;

  logic [CntW-1:0]  cnt_eff;
  logic [VecW:0]    in_use_w;
  logic [VecW-1:0]  in_use;
  logic             in_acc;
  logic             mem_we, mem_re;
  logic [VecW-1:0]  mem_rdata;
  cell_req_t        cell_req;
  logic             cell_alive;

  assign cnt_eff  = (count_q > 6'(MaxCells)) ? CntW'(MaxCells) : CntW'(count_q);
  assign in_use_w = ((VecW+1)'(1) << cnt_eff) - (VecW+1)'(1);
  assign in_use   = in_use_w[VecW-1:0];

  assign in_ready_o = (state_q == StIdle) && (!out_vld_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign mem_we = in_acc && (func_i == FuncLoadNbr) && (32'(cell_index_i) < MaxCells);
  assign mem_re = (state_q == StRun) && (iss_q < cnt_eff);

  gla_nbr_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (cell_index_i[IdxW-1:0]),
    .wdata_i (value_i),
    .re_i    (mem_re),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    cell_req.nbr        = mem_rdata;
    cell_req.alive      = alive_q;
    cell_req.in_use     = in_use;
    cell_req.birth      = birth_q;
    cell_req.survival   = survival_q;
    cell_req.self_alive = alive_q[rd_idx_q];
  end

  gla_cell_unit u_cell (
    .req_i   (cell_req),
    .alive_o (cell_alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q    <= '0;
      survival_q <= '0;
      count_q    <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegBirth:    birth_q    <= cfg_wdata_i;
        RegSurvival: survival_q <= cfg_wdata_i;
        RegCount:    count_q    <= cfg_wdata_i[5:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    alive_d    = alive_q;
    next_d     = next_q;
    iss_d      = iss_q;
    pend_d     = 1'b0;
    rd_idx_d   = rd_idx_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_data_d = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (func_i)
            FuncLoadState: begin
              alive_d    = value_i & CellMask;
              out_vld_d  = 1'b1;
              out_data_d = value_i & CellMask;
            end
            FuncStep: begin
              next_d  = alive_q;
              iss_d   = '0;
              state_d = StRun;
            end
            default: begin
              out_vld_d  = 1'b1;
              out_data_d = alive_q;
            end
          endcase
        end
      end
      StRun: begin
        // issue one read and retire the previous one each cycle
        if (pend_q) begin
          next_d[rd_idx_q] = cell_alive;
        end
        if (mem_re) begin
          pend_d   = 1'b1;
          rd_idx_d = iss_q[IdxW-1:0];
          iss_d    = iss_q + CntW'(1);
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        // hold until the output register is free
        if (!out_vld_q || out_ready_i) begin
          alive_d    = next_q & CellMask;
          out_vld_d  = 1'b1;
          out_data_d = next_q & CellMask;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      alive_q   <= '0;
      iss_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      alive_q   <= alive_d;
      iss_q     <= iss_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q     <= next_d;
    rd_idx_q   <= rd_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o   = out_vld_q;
  assign cell_states_o = out_data_q;

endmodule
`default_nettype wire

FILE: sv/gla_nbr_mem.sv
`default_nettype none
module gla_nbr_mem (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [gla_pkg::IdxW-1:0] waddr_i,
  input  wire logic [gla_pkg::VecW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [gla_pkg::IdxW-1:0] raddr_i,
  output logic      [gla_pkg::VecW-1:0] rdata_o
);
  import gla_pkg::*;

  logic [VecW-1:0]     mem_q [MaxCells];
  logic [MaxCells-1:0] vld_q;
  logic [VecW-1:0]     rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

FILE: sv/gla_cell_unit.sv
`default_nettype none
module gla_cell_unit (
  input  wire gla_pkg::cell_req_t req_i,
  output logic                    alive_o
);
  import gla_pkg::*;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(b[k]);
    end
    return c;
  endfunction

  logic [VecW-1:0] live_nbr;
  logic [4:0]      sum_lo;
  logic [4:0]      sum_hi;
  logic [5:0]      n_live;
  logic [RuleW-1:0] rule;

  assign live_nbr = req_i.nbr & req_i.alive & req_i.in_use;
  assign sum_lo   = 5'(popcnt8(live_nbr[7:0]))   + 5'(popcnt8(live_nbr[15:8]));
  assign sum_hi   = 5'(popcnt8(live_nbr[23:16])) + 5'(popcnt8(live_nbr[31:24]));
  assign n_live   = 6'(sum_lo) + 6'(sum_hi);
  assign rule     = req_i.self_alive ? req_i.survival : req_i.birth;
  assign alive_o  = rule[n_live];

endmodule
`default_nettype wire

FILE: sv/gla_step_chk.sv
`default_nettype none
module gla_step_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  func_i,
  input wire logic [31:0] value_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] cell_states_o
);
  import gla_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_states_o))
    else $error("result dropped or changed while stalled");

  // a new request is only taken when the output slot frees up
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_ready_i)
    else $error("request accepted over a pending result");

  // loading the state vector echoes it right away
  a_load_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_i == FuncLoadState
    |=> out_valid_o && cell_states_o == ($past(value_i) & CellMask))
    else $error("state load not returned");

  // a generation keeps the block busy past the next edge
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func_i == FuncStep |=> !in_ready_o && !out_valid_o)
    else $error("generation finished too early");

  // nothing beyond the 32 cell positions of CellMask shows up
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_states_o & ~CellMask) == '0)
    else $error("state bit beyond cell range");

endmodule

bind graph_life_automaton_step gla_step_chk u_gla_step_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .func_i        (func_i),
  .value_i       (value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .cell_states_o (cell_states_o)
);
`default_nettype wire
